// File: rtl/vga_text_line_generator_assert.svh
// assertion macros used by the line generator datapath
// needs a signal named clock and a synchronous reset named reset in scope
`ifndef VGA_TEXT_LINE_GENERATOR_ASSERT_SVH
`define VGA_TEXT_LINE_GENERATOR_ASSERT_SVH

// same-cycle implication, off during reset
`define VTLG_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, off during reset
`define VTLG_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/vtlg_pkg.sv
// shared types, codes and sizes of the text line generator
// no dependencies
`timescale 1ns / 1ps

package vtlg_pkg;

   // defaults of the top-level parameters
   localparam int ROWS_DEFAULT     = 32;
   localparam int MAX_COLS_DEFAULT = 32;

   // fixed geometry
   localparam int GLYPH_ROWS = 8;
   localparam int ROW_LINES  = 16;
   localparam int TB_DEPTH   = 1024;
   localparam int FS_DEPTH   = 2048;
   localparam int CHAR_W     = 8;
   localparam int COL_W      = 5;
   localparam int ROW_W      = 5;
   localparam int LINE_W     = 10;
   localparam int CCNT_W     = 6;
   localparam int GLYPH_W    = 3;

   // output queue
   localparam int FIFO_DEPTH = 4;
   localparam int PTR_W      = $clog2(FIFO_DEPTH);
   localparam int CNT_W      = PTR_W + 1;

   // request codes
   localparam logic [1:0] FUNC_VSYNC = 2'd0;
   localparam logic [1:0] FUNC_HSYNC = 2'd1;
   localparam logic [1:0] FUNC_TEXT  = 2'd2;
   localparam logic [1:0] FUNC_FONT  = 2'd3;

   // register indexes
   localparam logic [1:0] CSR_BACK_PORCH = 2'd0;
   localparam logic [1:0] CSR_VISIBLE    = 2'd1;
   localparam logic [1:0] CSR_COLUMNS    = 2'd2;

   typedef struct packed {
      logic vsync;
      logic write_text;
      logic write_font;
      logic porch_dec;
      logic start_line;
      logic issue;
      logic advance_line;
   } cmd_type;

   typedef struct packed {
      logic porch_busy;
      logic visible;
      logic cols_zero;
      logic issue_last;
      logic can_issue;
   } status_type;

   typedef struct packed {
      logic [CHAR_W-1:0] pixel_byte;
      logic [COL_W-1:0]  column;
      logic              last;
   } beat_type;

endpackage

// File: rtl/vtlg_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module vtlg_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // read returns the old word on a same-address collision
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/vtlg_ctrl.sv
// request sequencer: decodes each beat and walks the columns of a line
// depends on vtlg_pkg
`timescale 1ns / 1ps

module vtlg_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic [1:0]           req_func,
   output logic                 req_stall,
   input  vtlg_pkg::status_type status,
   output vtlg_pkg::cmd_type    cmd
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_RUN  = 1'b1;

   logic state_ff;
   logic state_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               unique case (req_func)
                  vtlg_pkg::FUNC_VSYNC: cmd.vsync      = 1'b1;
                  vtlg_pkg::FUNC_TEXT:  cmd.write_text = 1'b1;
                  vtlg_pkg::FUNC_FONT:  cmd.write_font = 1'b1;
                  vtlg_pkg::FUNC_HSYNC: begin
                     priority if (status.porch_busy) begin
                        cmd.porch_dec = 1'b1;
                     end else if (status.visible) begin
                        if (status.cols_zero) begin
                           cmd.advance_line = 1'b1;
                        end else begin
                           cmd.start_line = 1'b1;
                           state_in       = ST_RUN;
                        end
                     end else begin
                        // past the last visible line nothing happens
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_RUN: begin
            if (status.can_issue) begin
               cmd.issue = 1'b1;
               if (status.issue_last) begin
                  cmd.advance_line = 1'b1;
                  state_in         = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff == ST_RUN);

endmodule

// File: rtl/vtlg_datapath.sv
// line state, text and font rams, column read pipeline and output queue
// depends on vtlg_pkg, vtlg_ram and the assertion macro header
`timescale 1ns / 1ps
`include "vga_text_line_generator_assert.svh"

module vtlg_datapath #(
   parameter int ROWS     = vtlg_pkg::ROWS_DEFAULT,
   parameter int MAX_COLS = vtlg_pkg::MAX_COLS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [vtlg_pkg::ROW_W-1:0]    req_row_sel,
   input  logic [7:0]                    req_col_sel,
   input  logic [vtlg_pkg::CHAR_W-1:0]   req_wdata,
   input  logic                          csr_write,
   input  logic [1:0]                    csr_index,
   input  logic [vtlg_pkg::LINE_W-1:0]   csr_wdata,
   input  vtlg_pkg::cmd_type             cmd,
   output vtlg_pkg::status_type          status,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output vtlg_pkg::beat_type            rsp_beat
);

   localparam int LINE_W  = vtlg_pkg::LINE_W;
   localparam int ROW_W   = vtlg_pkg::ROW_W;
   localparam int COL_W   = vtlg_pkg::COL_W;
   localparam int CCNT_W  = vtlg_pkg::CCNT_W;
   localparam int GLYPH_W = vtlg_pkg::GLYPH_W;
   localparam int CHAR_W  = vtlg_pkg::CHAR_W;
   localparam int PTR_W   = vtlg_pkg::PTR_W;
   localparam int CNT_W   = vtlg_pkg::CNT_W;
   localparam int TB_AW   = $clog2(vtlg_pkg::TB_DEPTH);
   localparam int FS_AW   = $clog2(vtlg_pkg::FS_DEPTH);

   localparam logic [LINE_W-1:0] LINE_LIMIT = LINE_W'(ROWS * vtlg_pkg::ROW_LINES);
   localparam logic [CCNT_W-1:0] COL_LIMIT  = CCNT_W'(MAX_COLS);
   localparam logic [ROW_W:0]    ROW_LIMIT  = (ROW_W + 1)'(ROWS);
   localparam logic [CNT_W-1:0]  FIFO_FULL  = CNT_W'(vtlg_pkg::FIFO_DEPTH);

   // configuration
   logic [LINE_W-1:0] back_porch_ff;
   logic [LINE_W-1:0] visible_ff;
   logic [CCNT_W-1:0] columns_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         back_porch_ff <= '0;
         visible_ff    <= '0;
         columns_ff    <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            vtlg_pkg::CSR_BACK_PORCH: back_porch_ff <= csr_wdata;
            vtlg_pkg::CSR_VISIBLE:    visible_ff    <= csr_wdata;
            vtlg_pkg::CSR_COLUMNS:    columns_ff    <= csr_wdata[CCNT_W-1:0];
            default: ;
         endcase
      end
   end

   // line position
   logic [LINE_W-1:0] porch_left_ff, porch_left_in;
   logic [LINE_W-1:0] scan_line_ff, scan_line_in;
   logic [ROW_W-1:0]  text_row_ff, text_row_in;
   logic [COL_W-1:0]  col_cnt_ff, col_cnt_in;
   logic [LINE_W-1:0] lines_eff;
   logic [CCNT_W-1:0] cols_eff;
   logic [LINE_W-1:0] scan_next;

   assign lines_eff = (visible_ff > LINE_LIMIT) ? LINE_LIMIT : visible_ff;
   assign cols_eff  = (columns_ff > COL_LIMIT) ? COL_LIMIT : columns_ff;
   assign scan_next = scan_line_ff + LINE_W'(1);

   always_comb begin
      porch_left_in = porch_left_ff;
      scan_line_in  = scan_line_ff;
      text_row_in   = text_row_ff;
      col_cnt_in    = col_cnt_ff;
      if (cmd.vsync) begin
         porch_left_in = back_porch_ff;
         scan_line_in  = '0;
         text_row_in   = '0;
      end
      if (cmd.porch_dec) begin
         porch_left_in = porch_left_ff - LINE_W'(1);
      end
      if (cmd.start_line) begin
         col_cnt_in = '0;
      end
      if (cmd.issue) begin
         col_cnt_in = col_cnt_ff + COL_W'(1);
      end
      if (cmd.advance_line) begin
         scan_line_in = scan_next;
         // text row steps each time the line count crosses a cell height
         if (scan_next[3:0] == 4'd0) begin
            text_row_in = text_row_ff + ROW_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         porch_left_ff <= '0;
         scan_line_ff  <= '0;
         text_row_ff   <= '0;
         col_cnt_ff    <= '0;
      end else begin
         porch_left_ff <= porch_left_in;
         scan_line_ff  <= scan_line_in;
         text_row_ff   <= text_row_in;
         col_cnt_ff    <= col_cnt_in;
      end
   end

   // rams
   logic              text_we;
   logic              font_we;
   logic [CHAR_W-1:0] text_rdata;
   logic [CHAR_W-1:0] font_rdata;
   logic [TB_AW-1:0]  text_waddr;
   logic [TB_AW-1:0]  text_raddr;
   logic [FS_AW-1:0]  font_waddr;
   logic [FS_AW-1:0]  font_raddr;

   assign text_we = cmd.write_text && ({1'b0, req_row_sel} < ROW_LIMIT)
                    && (req_col_sel < 8'(MAX_COLS));
   assign font_we = cmd.write_font && (req_row_sel[ROW_W-1:GLYPH_W] == '0);

   assign text_waddr = {req_row_sel, req_col_sel[COL_W-1:0]};
   assign text_raddr = {text_row_ff, col_cnt_ff};
   assign font_waddr = {req_row_sel[GLYPH_W-1:0], req_col_sel};

   vtlg_ram #(
      .WIDTH (CHAR_W),
      .DEPTH (vtlg_pkg::TB_DEPTH)
   ) u_text_ram (
      .clock   (clock),
      .wr_en   (text_we),
      .wr_addr (text_waddr),
      .wr_data (req_wdata),
      .rd_addr (text_raddr),
      .rd_data (text_rdata)
   );

   vtlg_ram #(
      .WIDTH (CHAR_W),
      .DEPTH (vtlg_pkg::FS_DEPTH)
   ) u_font_ram (
      .clock   (clock),
      .wr_en   (font_we),
      .wr_addr (font_waddr),
      .wr_data (req_wdata),
      .rd_addr (font_raddr),
      .rd_data (font_rdata)
   );

   // read pipeline: stage 1 waits on the text cell, stage 2 on the font byte
   logic               s1_valid_ff, s2_valid_ff;
   logic [GLYPH_W-1:0] s1_glyph_ff;
   logic [COL_W-1:0]   s1_col_ff, s2_col_ff;
   logic               s1_last_ff, s2_last_ff;
   logic               issue_last;

   assign issue_last = ({1'b0, col_cnt_ff} + CCNT_W'(1)) == cols_eff;
   assign font_raddr = {s1_glyph_ff, text_rdata};

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= cmd.issue;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_glyph_ff <= scan_line_ff[GLYPH_W:1];
      s1_col_ff   <= col_cnt_ff;
      s1_last_ff  <= issue_last;
      s2_col_ff   <= s1_col_ff;
      s2_last_ff  <= s1_last_ff;
   end

   // output queue
   vtlg_pkg::beat_type fifo_ff [vtlg_pkg::FIFO_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]   fifo_cnt_ff;
   logic               fifo_push;
   logic               fifo_pop;
   logic [CNT_W-1:0]   credits_used;

   assign fifo_push = s2_valid_ff;
   assign fifo_pop  = rsp_valid && !rsp_stall;

   always_ff @(posedge clock) begin
      if (fifo_push) begin
         fifo_ff[wr_ptr_ff] <= '{pixel_byte: font_rdata, column: s2_col_ff, last: s2_last_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         fifo_cnt_ff <= '0;
      end else begin
         if (fifo_push) begin
            wr_ptr_ff <= wr_ptr_ff + PTR_W'(1);
         end
         if (fifo_pop) begin
            rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
         end
         fifo_cnt_ff <= fifo_cnt_ff + CNT_W'(fifo_push) - CNT_W'(fifo_pop);
      end
   end

   assign rsp_valid = (fifo_cnt_ff != '0);
   assign rsp_beat  = fifo_ff[rd_ptr_ff];

   // every beat in flight holds a queue slot in reserve
   assign credits_used = fifo_cnt_ff + CNT_W'(s1_valid_ff) + CNT_W'(s2_valid_ff);

   assign status.porch_busy = (porch_left_ff != '0);
   assign status.visible    = (scan_line_ff < lines_eff);
   assign status.cols_zero  = (cols_eff == '0);
   assign status.issue_last = issue_last;
   assign status.can_issue  = (credits_used < FIFO_FULL);

   `VTLG_ASSERT_SAME(a_push_has_room, fifo_push, (fifo_cnt_ff != FIFO_FULL) || fifo_pop, "queue overrun")
   `VTLG_ASSERT_SAME(a_credit_bound, 1'b1, credits_used <= FIFO_FULL, "reads in flight exceed queue room")
   `VTLG_ASSERT_NEXT(a_push_lands, s2_valid_ff, fifo_cnt_ff != '0, "pushed beat missing from queue")

endmodule

// File: rtl/vga_text_line_generator.sv
// top level of the text-mode line generator
// depends on vtlg_pkg, vtlg_ctrl, vtlg_datapath (and through it vtlg_ram)
//
//   channel  | direction | handshake         | payload
//   ---------+-----------+-------------------+----------------------------------
//   req      | in        | req_valid/stall   | func, row_sel, col_sel, wdata
//   rsp      | out       | rsp_valid/stall   | pixel_byte, column, last
//   csr      | in        | csr_valid/ready   | index, wdata (always ready)
//
// vsync, writes and hsyncs that emit nothing are taken without a stall.
// a visible hsync with n columns holds req_stall while one cell read is issued per
// cycle from the text ram while queue room allows; the font ram byte passes s1 and s2
// into a 4-deep queue; rsp stall fills it and holds further reads until a slot frees.
// synchronous reset clears counters and configuration; ram contents are undefined.
`timescale 1ns / 1ps

module vga_text_line_generator #(
   parameter int ROWS     = vtlg_pkg::ROWS_DEFAULT,
   parameter int MAX_COLS = vtlg_pkg::MAX_COLS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_func,
   input  logic [4:0]  req_row_sel,
   input  logic [7:0]  req_col_sel,
   input  logic [7:0]  req_wdata,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_pixel_byte,
   output logic [4:0]  rsp_column,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [9:0]  csr_wdata
);

   vtlg_pkg::cmd_type    cmd;
   vtlg_pkg::status_type status;
   vtlg_pkg::beat_type   rsp_beat;

   assign csr_ready = 1'b1;

   vtlg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_func),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   vtlg_datapath #(
      .ROWS     (ROWS),
      .MAX_COLS (MAX_COLS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_row_sel (req_row_sel),
      .req_col_sel (req_col_sel),
      .req_wdata   (req_wdata),
      .csr_write   (csr_valid && csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .cmd         (cmd),
      .status      (status),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_beat    (rsp_beat)
   );

   assign rsp_pixel_byte = rsp_beat.pixel_byte;
   assign rsp_column     = rsp_beat.column;
   assign rsp_last       = rsp_beat.last;

endmodule
